FILE: rtl/ktaf_pkg.sv
// Shared types, constants and helpers for the two-state tilt Kalman filter.
// Used by the controller, the datapath and the top level.
`default_nettype none
package ktaf_pkg;

  localparam int DataWidthDef = 32;
  localparam int FracBitsDef  = 16;
  localparam int CfgBits      = 24;
  localparam int IdxBits      = 2;

  localparam logic [IdxBits-1:0] RegQAngle = 2'd0;
  localparam logic [IdxBits-1:0] RegQBias  = 2'd1;
  localparam logic [IdxBits-1:0] RegR      = 2'd2;
  localparam logic [IdxBits-1:0] RegDt     = 2'd3;

  localparam logic [CfgBits-1:0] QAngleRst = 24'd16777;
  localparam logic [CfgBits-1:0] QBiasRst  = 24'd50332;
  localparam logic [CfgBits-1:0] RRst      = 24'd8388608;
  localparam logic [CfgBits-1:0] DtRst     = 24'd335544;

  // Sequencer steps; each step but idle and output issues one operation to the datapath.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PRED_A, ST_PRED_P00A, ST_PRED_P00B, ST_PRED_P01, ST_PRED_P11,
    ST_PRED_FIN,
    ST_DIV_P00, ST_DIV_P01, ST_DIV_P10, ST_DIV_P11, ST_DIV_ANG, ST_DIV_BIAS,
    ST_FIN,
    ST_OUT
  } ktaf_state_e;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PRED_A, OP_PRED_P00A, OP_PRED_P00B, OP_PRED_P01, OP_PRED_P11,
    OP_PRED_FIN,
    OP_DIV_P00, OP_DIV_P01, OP_DIV_P10, OP_DIV_P11, OP_DIV_ANG, OP_DIV_BIAS,
    OP_FIN
  } ktaf_op_e;

  typedef struct packed {
    logic     start;
    ktaf_op_e op;
  } ktaf_cmd_t;

  typedef struct packed {
    logic busy;
    logic e_pos;
  } ktaf_sts_t;

endpackage
`default_nettype wire

FILE: rtl/ktaf_ctrl.sv
// Sequencer for the tilt filter: steps through predict and correct operations.
// Depends on ktaf_pkg.
`default_nettype none
module ktaf_ctrl
  import ktaf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_fire_i,
  input  logic      out_free_i,
  input  ktaf_sts_t sts_i,
  output ktaf_cmd_t cmd_o,
  output logic      idle_o,
  output logic      out_load_o
);

  ktaf_state_e state_q, state_d;
  logic        issued_q, issued_d;

  // Next state: issue once per step, advance when the unit is done.
  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          state_d  = ST_PRED_A;
          issued_d = 1'b0;
        end
      end
      ST_OUT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: begin
        if (!issued_q) begin
          issued_d = 1'b1;
        end else if (!sts_i.busy) begin
          issued_d = 1'b0;
          case (state_q)
            ST_PRED_A:    state_d = ST_PRED_P00A;
            ST_PRED_P00A: state_d = ST_PRED_P00B;
            ST_PRED_P00B: state_d = ST_PRED_P01;
            ST_PRED_P01:  state_d = ST_PRED_P11;
            ST_PRED_P11:  state_d = ST_PRED_FIN;
            ST_PRED_FIN:  state_d = sts_i.e_pos ? ST_DIV_P00 : ST_FIN;
            ST_DIV_P00:   state_d = ST_DIV_P01;
            ST_DIV_P01:   state_d = ST_DIV_P10;
            ST_DIV_P10:   state_d = ST_DIV_P11;
            ST_DIV_P11:   state_d = ST_DIV_ANG;
            ST_DIV_ANG:   state_d = ST_DIV_BIAS;
            ST_DIV_BIAS:  state_d = ST_FIN;
            default:      state_d = ST_OUT;
          endcase
        end
      end
    endcase
  end

  // Outputs: one start pulse per step with its operation code.
  always_comb begin
    cmd_o.start = 1'b0;
    cmd_o.op    = OP_NONE;
    case (state_q)
      ST_PRED_A:    cmd_o.op = OP_PRED_A;
      ST_PRED_P00A: cmd_o.op = OP_PRED_P00A;
      ST_PRED_P00B: cmd_o.op = OP_PRED_P00B;
      ST_PRED_P01:  cmd_o.op = OP_PRED_P01;
      ST_PRED_P11:  cmd_o.op = OP_PRED_P11;
      ST_PRED_FIN:  cmd_o.op = OP_PRED_FIN;
      ST_DIV_P00:   cmd_o.op = OP_DIV_P00;
      ST_DIV_P01:   cmd_o.op = OP_DIV_P01;
      ST_DIV_P10:   cmd_o.op = OP_DIV_P10;
      ST_DIV_P11:   cmd_o.op = OP_DIV_P11;
      ST_DIV_ANG:   cmd_o.op = OP_DIV_ANG;
      ST_DIV_BIAS:  cmd_o.op = OP_DIV_BIAS;
      ST_FIN:       cmd_o.op = OP_FIN;
      default:      cmd_o.op = OP_NONE;
    endcase
    if (cmd_o.op != OP_NONE) cmd_o.start = !issued_q;
    idle_o     = (state_q == ST_IDLE);
    out_load_o = (state_q == ST_OUT) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

`ifndef SYNTHESIS
  a_start_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> !idle_o) else $error("start issued while idle");
  a_start_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> !cmd_o.start) else $error("double start");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_o && in_fire_i) |=> (state_q == ST_PRED_A)) else $error("bad entry");
`endif

endmodule
`default_nettype wire

FILE: rtl/ktaf_dp.sv
// Datapath of the tilt filter: state, a shared multiplier and a bit-serial
// divider. Depends on ktaf_pkg.
`default_nettype none
module ktaf_dp
  import ktaf_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_load_i,
  input  logic signed [DATA_WIDTH-1:0] meas_i,
  input  logic signed [DATA_WIDTH-1:0] gyro_i,
  input  logic        [CfgBits-1:0]    q_angle_i,
  input  logic        [CfgBits-1:0]    q_bias_i,
  input  logic        [CfgBits-1:0]    r_i,
  input  logic        [CfgBits-1:0]    dt_i,
  input  ktaf_cmd_t                    cmd_i,
  output ktaf_sts_t                    sts_o,
  output logic signed [DATA_WIDTH-1:0] angle_o,
  output logic signed [DATA_WIDTH-1:0] rate_o
);

  localparam int W   = 64;
  localparam int PW  = 128;
  localparam int CntW = 8;
  localparam logic [W-1:0] Cap = {2'b01, {(W-2){1'b0}}};
  localparam logic signed [W-1:0] SatHi = (W)'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
  localparam logic signed [W-1:0] SatLo = -SatHi - 1;
  localparam int QShift = 2*CfgBits - FRAC_BITS;
  localparam int RShift = CfgBits - FRAC_BITS;

  function automatic logic signed [W-1:0] sat_f(input logic signed [W-1:0] v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  // Capped signed value of a 128-bit magnitude.
  function automatic logic signed [W-1:0] cap_f(input logic [PW-1:0] m, input logic neg);
    logic [W-1:0] c;
    c = (m > PW'(Cap)) ? Cap : m[W-1:0];
    return neg ? W'(-c) : c;
  endfunction

  // round(m / 2^s) ties away, on magnitude
  function automatic logic [PW-1:0] rsh_f(input logic [PW-1:0] m, input int s);
    logic [PW:0] t;
    if (s == 0) return m;
    t = {1'b0, m} + ((PW+1)'(1) << (s-1));
    return PW'(t >> s);
  endfunction

  // Filter state and working registers
  logic signed [W-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [W-1:0] a_q, n00_q, n01_q, n10_q, n11_q, e_q, err_q, meas_q, gyro_q;
  logic signed [W-1:0] t_q;
  logic                epos_q;

  // Serial multiplier/divider: operands, product, shift counter
  logic [W-1:0]  ma_q, mb_q;
  logic [PW-1:0] prod_q, num_q;
  logic [W:0]    rem_q;
  logic [W-1:0]  quo_q;
  logic          over_q, neg_q;
  logic [CntW-1:0] cnt_q;
  typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_DONE} ktaf_unit_e;
  ktaf_unit_e  unit_q;
  ktaf_op_e    op_q;
  logic        div_q;
  logic [6:0]  sh_q;

  logic signed [W-1:0] opa, opb;
  logic                use_div;
  logic [6:0]          sh;
  logic signed [W-1:0] res;
  logic [W:0]          rem_sh;
  logic [W-1:0]        divisor;
  logic [PW-1:0]       prod_nxt;

  // Operand selection for each operation
  always_comb begin
    opa = '0; opb = '0; use_div = 1'b0; sh = 7'd0;
    case (cmd_i.op)
      OP_PRED_A:    begin opa = W'(gyro_q) - bias_q; opb = W'(dt_i); sh = 7'(CfgBits); end
      OP_PRED_P00A: begin opa = W'(q_angle_i); opb = W'(dt_i); sh = 7'(QShift); end
      OP_PRED_P00B: begin opa = -(p01_q + p10_q); opb = W'(dt_i); sh = 7'(CfgBits); end
      OP_PRED_P01:  begin opa = -p11_q; opb = W'(dt_i); sh = 7'(CfgBits); end
      OP_PRED_P11:  begin opa = W'(q_bias_i); opb = W'(dt_i); sh = 7'(QShift); end
      OP_DIV_P00:   begin opa = n00_q; opb = n00_q; use_div = 1'b1; end
      OP_DIV_P01:   begin opa = n00_q; opb = n01_q; use_div = 1'b1; end
      OP_DIV_P10:   begin opa = n10_q; opb = n00_q; use_div = 1'b1; end
      OP_DIV_P11:   begin opa = n10_q; opb = n01_q; use_div = 1'b1; end
      OP_DIV_ANG:   begin opa = n00_q; opb = err_q; use_div = 1'b1; end
      OP_DIV_BIAS:  begin opa = n10_q; opb = err_q; use_div = 1'b1; end
      default:      ;
    endcase
  end

  assign divisor = e_q;
  assign rem_sh  = {rem_q[W-1:0], num_q[PW-1]};

  // Partial product sum for the current two multiplier bits
  assign prod_nxt = prod_q + (PW'(mb_q[0] ? ma_q : '0) << cnt_q)
                           + (PW'(mb_q[1] ? ma_q : '0) << (cnt_q + 1));

  // Result of the finished unit
  always_comb begin
    if (div_q) begin
      if (over_q) res = cap_f({{(PW-1){1'b0}}, 1'b1} << W, neg_q);
      else res = cap_f(PW'(quo_q) + PW'((rem_q >= ((W+1)'(divisor) - rem_q)) ? 1 : 0),
                       neg_q);
    end else begin
      res = cap_f(rsh_f(prod_q, int'(sh_q)), neg_q);
    end
  end

  assign sts_o.busy  = (unit_q != U_IDLE) || cmd_i.start;
  assign sts_o.e_pos = epos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= U_IDLE;
      ang_q  <= '0;
      bias_q <= '0;
      p00_q  <= W'(64'sd1 <<< FRAC_BITS);
      p01_q  <= '0;
      p10_q  <= '0;
      p11_q  <= W'(64'sd1 <<< FRAC_BITS);
      a_q    <= '0;
      n00_q  <= '0;
      n01_q  <= '0;
      n10_q  <= '0;
      n11_q  <= '0;
      e_q    <= '0;
      err_q  <= '0;
      meas_q <= '0;
      gyro_q <= '0;
      t_q    <= '0;
      epos_q <= 1'b0;
      ma_q   <= '0;
      mb_q   <= '0;
      prod_q <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      over_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_NONE;
      div_q  <= 1'b0;
      sh_q   <= '0;
    end else begin
      if (in_load_i) begin
        meas_q <= W'(meas_i);
        gyro_q <= W'(gyro_i);
      end
      case (unit_q)
        U_IDLE: begin
          if (cmd_i.start) begin
            op_q  <= cmd_i.op;
            sh_q  <= sh;
            div_q <= use_div;
            neg_q <= opa[W-1] ^ opb[W-1];
            ma_q  <= mag_f(opa);
            mb_q  <= mag_f(opb);
            prod_q <= '0;
            cnt_q <= '0;
            if (cmd_i.op == OP_PRED_FIN || cmd_i.op == OP_FIN) unit_q <= U_DONE;
            else unit_q <= U_MUL;
          end
        end
        // Shift-add: two bits of the multiplier per cycle
        U_MUL: begin
          prod_q <= prod_nxt;
          mb_q   <= mb_q >> 2;
          if (cnt_q == CntW'(W-2)) begin
            if (div_q) begin
              unit_q <= U_DIV;
              cnt_q  <= '0;
              rem_q  <= '0;
              quo_q  <= '0;
              over_q <= 1'b0;
              num_q  <= prod_nxt;
            end else begin
              unit_q <= U_DONE;
            end
          end else begin
            cnt_q <= cnt_q + CntW'(2);
          end
        end
        // Restoring divide, one quotient bit per cycle
        U_DIV: begin
          num_q <= num_q << 1;
          cnt_q <= cnt_q + CntW'(1);
          if (rem_sh >= (W+1)'(divisor)) begin
            rem_q <= rem_sh - (W+1)'(divisor);
            if (cnt_q < CntW'(W)) over_q <= 1'b1;
            else quo_q <= {quo_q[W-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            if (cnt_q >= CntW'(W)) quo_q <= {quo_q[W-2:0], 1'b0};
          end
          if (cnt_q == CntW'(PW-1)) unit_q <= U_DONE;
        end
        // Write back the step's result
        default: begin
          unit_q <= U_IDLE;
          case (op_q)
            OP_PRED_A:    a_q <= sat_f(ang_q + res);
            OP_PRED_P00A: t_q <= p00_q + res;
            OP_PRED_P00B: n00_q <= sat_f(t_q + res);
            OP_PRED_P01: begin
              n01_q <= sat_f(p01_q + res);
              n10_q <= sat_f(p10_q + res);
            end
            OP_PRED_P11:  n11_q <= sat_f(p11_q + res);
            OP_PRED_FIN: begin
              e_q    <= W'(cap_f(rsh_f(PW'(r_i), RShift), 1'b0)) + n00_q;
              epos_q <= !((W'(cap_f(rsh_f(PW'(r_i), RShift), 1'b0)) + n00_q) <= 0);
              err_q  <= meas_q - a_q;
              p00_q <= n00_q; p01_q <= n01_q; p10_q <= n10_q; p11_q <= n11_q;
              ang_q <= a_q;
            end
            OP_DIV_P00:  p00_q  <= sat_f(n00_q - res);
            OP_DIV_P01:  p01_q  <= sat_f(n01_q - res);
            OP_DIV_P10:  p10_q  <= sat_f(n10_q - res);
            OP_DIV_P11:  p11_q  <= sat_f(n11_q - res);
            OP_DIV_ANG:  ang_q  <= sat_f(a_q - 0 + res);
            OP_DIV_BIAS: bias_q <= sat_f(bias_q + res);
            default: ;
          endcase
        end
      endcase
    end
  end

  assign angle_o = DATA_WIDTH'(ang_q);
  assign rate_o  = DATA_WIDTH'(sat_f(gyro_q - bias_q));

`ifndef SYNTHESIS
  a_div_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (unit_q == U_DIV) |-> (e_q > 0)) else $error("divide by non-positive");
  a_ang_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ang_q <= SatHi) && (ang_q >= SatLo)) else $error("angle out of range");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (unit_q == U_DONE) |=> (unit_q == U_IDLE)) else $error("unit hung");
`endif

endmodule
`default_nettype wire

FILE: rtl/kalman_tilt_angle_filter_unit.sv
// Two-state Kalman tilt filter (angle and gyro bias) for one axis.
//
// Use: s_axis carries one sample per request: tdata = {gyro_rate,
// measured_angle}, measured_angle in the low bits, both signed Q15.16.
// m_axis returns {corrected_rate, fused_angle}, fused_angle low.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle, a
// rule on the user that the block itself leaves unchecked: 0 angle process
// noise, 1 bias process noise, 2 measurement noise, 3 sample period, all
// unsigned Q0.24. Other indexes are ignored. Steps: five multiply steps
// (shared shift-add multiplier, 2 bits a cycle), an innovation step, six
// multiply-divide steps (restoring divider, 1 quotient bit a cycle over 128
// bits), a finish step and an output step; the divide steps are skipped
// when the innovation is not positive. One sample in flight at a time: the
// block takes the next sample only after the last result has been taken.
// Reset clears the estimates to zero and the covariance to identity, and
// loads default register values. A stalled receiver holds the result in
// the output register; s_axis_tready stays low until it is taken.
// Depends on ktaf_pkg, ktaf_ctrl and ktaf_dp.
`default_nettype none
module kalman_tilt_angle_filter_unit
  import ktaf_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [DATA_WIDTH-1:0] measured_angle, [2*DATA_WIDTH-1:DATA_WIDTH] gyro_rate
  input  logic [2*DATA_WIDTH-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [DATA_WIDTH-1:0] fused_angle, [2*DATA_WIDTH-1:DATA_WIDTH] corrected_rate
  output logic [2*DATA_WIDTH-1:0] m_axis_tdata,
  input  logic                    cfg_we_i,
  input  logic [IdxBits-1:0]      cfg_idx_i,
  input  logic [CfgBits-1:0]      cfg_data_i
);

  logic [CfgBits-1:0] q_angle_q, q_bias_q, r_q, dt_q;
  ktaf_cmd_t cmd;
  ktaf_sts_t sts;
  logic idle, out_load, in_fire, out_free;
  logic signed [DATA_WIDTH-1:0] ang, rate;
  logic [2*DATA_WIDTH-1:0] out_q;
  logic out_vld_q;

  assign s_axis_tready = idle && !out_vld_q;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_angle_q <= QAngleRst;
      q_bias_q  <= QBiasRst;
      r_q       <= RRst;
      dt_q      <= DtRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegQAngle: q_angle_q <= cfg_data_i;
        RegQBias:  q_bias_q  <= cfg_data_i;
        RegR:      r_q       <= cfg_data_i;
        RegDt:     dt_q      <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  ktaf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_free_i(out_free),
    .sts_i(sts), .cmd_o(cmd), .idle_o(idle), .out_load_o(out_load)
  );

  ktaf_dp #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .in_load_i(in_fire),
    .meas_i(s_axis_tdata[DATA_WIDTH-1:0]),
    .gyro_i(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .q_angle_i(q_angle_q), .q_bias_i(q_bias_q), .r_i(r_q), .dt_i(dt_q),
    .cmd_i(cmd), .sts_o(sts), .angle_o(ang), .rate_o(rate)
  );

  // Output register: hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      if (out_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= {rate, ang};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !out_vld_q) else $error("accept with pending result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid) else $error("result lost");
`endif

endmodule
`default_nettype wire

FILE: bench/ktaf_checker.sv
// Checker for the tilt Kalman filter: watches the sample, result and register
// channels, predicts each result and compares it. Depends on ktaf_pkg.
`timescale 1ns / 1ps
module ktaf_checker
  import ktaf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               s_ready_i,
  input  logic [63:0]        s_data_i,
  input  logic               m_valid_i,
  input  logic               m_ready_i,
  input  logic [63:0]        m_data_i,
  input  logic               cfg_we_i,
  input  logic [IdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0] cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam longint MagCap = 64'sd1 << 62;

  // Filter state as the block should hold it
  longint q_angle, q_bias, r_noise, dt;
  longint ang_est, bias_est;
  longint p00, p01, p10, p11;
  logic [63:0] fused_q[$];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint capped(logic [127:0] m, bit neg);
    logic [127:0] lim;
    longint r;
    lim = 128'd1 << 62;
    r = (m > lim) ? MagCap : longint'(m[63:0]);
    return neg ? -r : r;
  endfunction

  // round(a*b / 2^s), ties away from zero
  function automatic longint mul_rnd(longint a, longint b, int s);
    logic [63:0] ma, mb;
    logic [127:0] p;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ma} * {64'd0, mb};
    if (s > 0) p = (p + (128'd1 << (s - 1))) >> s;
    return capped(p, (a < 0) != (b < 0));
  endfunction

  // round(a*b / d), ties away from zero, d > 0
  function automatic longint mul_dvd(longint a, longint b, longint d);
    logic [63:0] ma, mb, q64;
    logic [127:0] p, q, rm, ud;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ma} * {64'd0, mb};
    ud = {64'd0, 64'(d)};
    q = p / ud;
    rm = p % ud;
    if (q[127:64] != 0) return neg ? -MagCap : MagCap;
    q64 = q[63:0];
    if (rm >= ud - rm) q64 = q64 + 64'd1;
    return capped({64'd0, q64}, neg);
  endfunction

  // Advance the filter by one sample and return {corrected_rate, fused_angle}
  function automatic logic [63:0] filter_step(logic [63:0] sample);
    longint meas, gyro, a, n00, n01, n10, n11, e, err;
    meas = longint'(signed'(sample[31:0]));
    gyro = longint'(signed'(sample[63:32]));
    a = sat32(ang_est + mul_rnd(gyro - bias_est, dt, CfgBits));
    n00 = sat32(p00 + mul_rnd(q_angle, dt, 2 * CfgBits - FracBitsDef)
                + mul_rnd(-(p01 + p10), dt, CfgBits));
    n01 = sat32(p01 + mul_rnd(-p11, dt, CfgBits));
    n10 = sat32(p10 + mul_rnd(-p11, dt, CfgBits));
    n11 = sat32(p11 + mul_rnd(q_bias, dt, 2 * CfgBits - FracBitsDef));
    e = mul_rnd(r_noise, 1, CfgBits - FracBitsDef) + n00;
    err = meas - a;
    if (e > 0) begin
      p00 = sat32(n00 - mul_dvd(n00, n00, e));
      p01 = sat32(n01 - mul_dvd(n00, n01, e));
      p10 = sat32(n10 - mul_dvd(n10, n00, e));
      p11 = sat32(n11 - mul_dvd(n10, n01, e));
      ang_est = sat32(a + mul_dvd(n00, err, e));
      bias_est = sat32(bias_est + mul_dvd(n10, err, e));
    end else begin
      // Non-positive innovation: keep the prediction, hold the bias
      p00 = n00;
      p01 = n01;
      p10 = n10;
      p11 = n11;
      ang_est = a;
    end
    return {32'(sat32(gyro - bias_est)), 32'(ang_est)};
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  // Track registers, predict on each sample request, compare each result
  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    if (!rst_ni) begin
      q_angle  = QAngleRst;
      q_bias   = QBiasRst;
      r_noise  = RRst;
      dt       = DtRst;
      ang_est  = 0;
      bias_est = 0;
      p00 = 64'sd1 << FracBitsDef;
      p01 = 0;
      p10 = 0;
      p11 = 64'sd1 << FracBitsDef;
      fused_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegQAngle: q_angle = cfg_data_i;
          RegQBias:  q_bias  = cfg_data_i;
          RegR:      r_noise = cfg_data_i;
          RegDt:     dt      = cfg_data_i;
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        if (fused_q.size() == 0) begin
          report_mismatch("unexpected result", m_data_i[31:0], 32'd0);
        end else begin
          want = fused_q.pop_front();
          if (m_data_i[31:0] !== want[31:0])
            report_mismatch("fused_angle", m_data_i[31:0], want[31:0]);
          if (m_data_i[63:32] !== want[63:32])
            report_mismatch("corrected_rate", m_data_i[63:32], want[63:32]);
        end
      end
      if (s_valid_i && s_ready_i) fused_q.push_back(filter_step(s_data_i));
      pending_o = fused_q.size();
    end
  end

endmodule

FILE: bench/tb_kalman_tilt_angle_filter_unit.sv
// Top of the tilt Kalman filter bench: clock, reset, sample stimulus,
// register phases and the verdict. Depends on ktaf_pkg and ktaf_checker.
`timescale 1ns / 1ps
module tb_kalman_tilt_angle_filter_unit;
  import ktaf_pkg::*;

  localparam int CycleLimit = 8000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [63:0]        m_axis_tdata;
  logic               cfg_we_i = 1'b0;
  logic [IdxBits-1:0] cfg_idx_i = '0;
  logic [CfgBits-1:0] cfg_data_i = '0;

  int  fail_count, pending;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 1'b0;
  longint cycles = 0;

  always #5 clk_i = ~clk_i;

  kalman_tilt_angle_filter_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  ktaf_checker u_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Drive the result-side ready: random stalls or a long hold-off
  always @(posedge clk_i) begin
    if (recv_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one sample request and hold it until taken, then maybe idle
  task automatic send_sample(logic [31:0] angle, logic [31:0] rate);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rate, angle};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Lower valid and wait until every expected result has come
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [CfgBits-1:0] qa, logic [CfgBits-1:0] qb,
                            logic [CfgBits-1:0] rn, logic [CfgBits-1:0] sp);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegQAngle; cfg_data_i <= qa; @(posedge clk_i);
    cfg_idx_i <= RegQBias;  cfg_data_i <= qb; @(posedge clk_i);
    cfg_idx_i <= RegR;      cfg_data_i <= rn; @(posedge clk_i);
    cfg_idx_i <= RegDt;     cfg_data_i <= sp; @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly plausible tilt samples, some full-range noise
  task automatic send_random();
    logic [31:0] angle, rate;
    if ($urandom_range(99) < 70) begin
      angle = 32'($signed($urandom_range(0, 180 << 16)) - (90 << 16));
      rate  = 32'($signed($urandom_range(0, 1000 << 16)) - (500 << 16));
    end else begin
      angle = $urandom;
      rate  = $urandom;
    end
    send_sample(angle, rate);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default: begin send_idle_pct = 24; recv_stall_pct = 24; end
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes with reset registers
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000);
    send_sample(32'h7fff_ffff, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7fff_ffff);
    send_sample(32'hffff_ffff, 32'h0000_0001);
    send_sample(32'h002d_0000, 32'hfff6_0000);
    drain();

    // No noise and no time step: covariance collapses, innovation goes to zero
    write_regs('0, '0, '0, '0);
    repeat (4) send_sample(32'h0010_0000, 32'h0003_0000);
    drain();
    write_regs('1, '1, '1, '1);
    repeat (4) send_sample($urandom, $urandom);
    drain();

    // Random phases over register settings and idling modes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_regs(QAngleRst, QBiasRst, RRst, DtRst);
        1: write_regs('1, '1, '1, '1);
        2: write_regs('0, '0, '0, CfgBits'($urandom_range(1, 16)));
        3: write_regs(CfgBits'($urandom), CfgBits'($urandom), CfgBits'($urandom),
                      CfgBits'($urandom));
        default: write_regs(CfgBits'($urandom_range(0, 1 << 16)),
                            CfgBits'($urandom_range(0, 1 << 17)),
                            CfgBits'($urandom_range(1 << 20, 1 << 23)),
                            CfgBits'($urandom_range(1 << 16, 1 << 20)));
      endcase
      set_idling(ph % 4);
      for (int n = 0; n < 175; n++) begin
        if (ph == 1 && n == 40) begin
          // Long receiver hold-off while samples keep coming
          fork
            begin
              recv_hold = 1'b1;
              repeat (6000) @(posedge clk_i);
              recv_hold = 1'b0;
            end
          join_none
        end
        if (ph == 2 && n == 80) drain();
        send_random();
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
